@@ design/sppg_pkg.sv @@
// sppg_pkg: shared types, codes, constants and the sine ROM function for the
// sine pattern pixel generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sppg_pkg;

	localparam int MAX_DIM_DEFAULT = 1024;

	localparam int PIX_W     = 10;
	localparam int FRAME_W   = 16;
	localparam int OFS_W     = 8;
	localparam int PAL_IDX_W = 8;
	localparam int COLOR_W   = 16;
	localparam int DIM_W     = 11;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int PAL_DEPTH = 256;
	// squared distance is only needed up to the bits that reach (d2 >> 7)[7:0]
	localparam int D2_W      = 15;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd172;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd320;

	// operation codes
	localparam logic OP_PIXEL         = 1'b0;
	localparam logic OP_PALETTE_WRITE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE = 2'd2;

	typedef enum logic [MODE_W-1:0] {
		MODE_PLASMA = 2'd0,
		MODE_RINGS  = 2'd1,
		MODE_WEAVE  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [DIM_W-1:0]  frame_width;
		logic [DIM_W-1:0]  frame_height;
		logic [MODE_W-1:0] pattern_mode;
	} sppg_cfg_t;

	// floor(sin(2*pi*k/256)*127 + 128), k = 0..64
	localparam logic [7:0] QUARTER_WAVE [65] = '{
		8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
		8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd185,
		8'd187, 8'd190, 8'd193, 8'd195, 8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd210,
		8'd213, 8'd215, 8'd217, 8'd219, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd231,
		8'd233, 8'd235, 8'd236, 8'd238, 8'd240, 8'd241, 8'd242, 8'd244, 8'd245, 8'd246,
		8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254,
		8'd254, 8'd254, 8'd254, 8'd254, 8'd255
	};

	function automatic logic [7:0] sine_lut(input logic [7:0] q);
		logic [7:0] mirror;
		logic [7:0] res;
		mirror = 8'd0;
		if (q <= 8'd64) begin
			res = QUARTER_WAVE[q[6:0]];
		end else if (q < 8'd128) begin
			mirror = 8'd128 - q;
			res = QUARTER_WAVE[mirror[6:0]];
		end else if (q == 8'd128) begin
			res = 8'd128;
		end else if (q < 8'd192) begin
			mirror = q - 8'd128;
			res = 8'd255 - QUARTER_WAVE[mirror[6:0]];
		end else if (q == 8'd192) begin
			res = 8'd1;
		end else begin
			mirror = 8'd0 - q;
			res = 8'd255 - QUARTER_WAVE[mirror[6:0]];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

@@ design/sppg_ram.sv @@
// sppg_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sppg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/sppg_index.sv @@
// sppg_index: palette index for one pixel in plasma, rings or weave mode.
// Depends on sppg_pkg (sine ROM, mode codes, config struct).
`timescale 1ns / 1ps
`default_nettype none

module sppg_index #(
	parameter int MAX_DIM = sppg_pkg::MAX_DIM_DEFAULT
) (
	input  wire sppg_pkg::sppg_cfg_t                  cfg,
	input  wire logic [sppg_pkg::PIX_W-1:0]           pixel_x,
	input  wire logic [sppg_pkg::PIX_W-1:0]           pixel_y,
	input  wire logic [sppg_pkg::FRAME_W-1:0]         frame_count,
	input  wire logic signed [sppg_pkg::OFS_W-1:0]    offset_x,
	input  wire logic signed [sppg_pkg::OFS_W-1:0]    offset_y,
	output      logic [sppg_pkg::PAL_IDX_W-1:0]       palette_addr
);

	import sppg_pkg::*;

	localparam int MAXD_W = $clog2(MAX_DIM + 1);
	localparam int CMP_W  = (MAXD_W > DIM_W) ? MAXD_W : DIM_W;

	logic [7:0]       t;
	logic [6:0]       t_half;
	logic [8:0]       xx, yy, sum_xy, dif_xy;
	logic [7:0]       s_x, s_y, s_sum_p, s_dif, s_sum_w, s_ring;
	logic [9:0]       plasma_v;
	logic [15:0]      weave_ab;
	logic [8:0]       weave_v;
	logic [DIM_W-1:0] width_c, height_c;
	logic [D2_W-1:0]  cx, cy, dx, dy, sq_x, sq_y, d2;

	always_comb begin
		t      = frame_count[8:1];
		t_half = frame_count[8:2];

		// only bits [8:0] of the wrapped coordinates reach the indexes
		xx     = 9'(pixel_x) + {offset_x[OFS_W-1], offset_x};
		yy     = 9'(pixel_y) + {offset_y[OFS_W-1], offset_y};
		sum_xy = xx + yy;
		dif_xy = xx - yy;

		s_x     = sine_lut(xx[7:0] + t);
		s_y     = sine_lut(yy[7:0] + 8'(t_half));
		s_sum_p = sine_lut(sum_xy[8:1] + t);
		s_dif   = sine_lut(dif_xy[8:1] - t);
		s_sum_w = sine_lut(sum_xy[8:1] - t);

		plasma_v = 10'(s_x) + 10'(s_y) + 10'(s_sum_p) + 10'(s_dif);

		weave_ab = 16'(s_x) * 16'(s_y);
		weave_v  = 9'(weave_ab[15:8]) + 9'(s_sum_w);

		// ring centre from clamped dimensions; squares kept mod 2^D2_W
		width_c  = (CMP_W'(cfg.frame_width) > CMP_W'(MAX_DIM)) ?
			DIM_W'(MAX_DIM) : cfg.frame_width;
		height_c = (CMP_W'(cfg.frame_height) > CMP_W'(MAX_DIM)) ?
			DIM_W'(MAX_DIM) : cfg.frame_height;
		cx   = D2_W'(width_c[DIM_W-1:1]) + {{(D2_W-OFS_W){offset_x[OFS_W-1]}}, offset_x};
		cy   = D2_W'(height_c[DIM_W-1:1]) + {{(D2_W-OFS_W){offset_y[OFS_W-1]}}, offset_y};
		dx   = D2_W'(pixel_x) - cx;
		dy   = D2_W'(pixel_y) - cy;
		sq_x = dx * dx;
		sq_y = dy * dy;
		d2   = sq_x + sq_y;
		s_ring = sine_lut(d2[14:7] - t);

		case (cfg.pattern_mode)
			MODE_RINGS: palette_addr = s_ring + frame_count[10:3];
			MODE_WEAVE: palette_addr = weave_v[8:1] + frame_count[9:2];
			default:    palette_addr = plasma_v[9:2] + frame_count[9:2];
		endcase
	end

endmodule

`default_nettype wire

@@ design/sine_pattern_pixel_generator_top.sv @@
// sine_pattern_pixel_generator_top: input register, index logic, palette RAM and
// result stage. Depends on sppg_pkg, sppg_index and sppg_ram.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | signals                                              | dir
//  ---------+------------------------------------------------------+-----
//  in       | in_valid, in_stall, operation .. palette_color       | in
//  out      | out_valid, out_stall, pixel_color                    | out
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data            | in
//
// One transaction per clock while in_stall is low; a pixel's result is valid on the
// output after the input register, index register and palette RAM read register.
// Palette writes take the same path and give no result.
// Stalls back up the three stages; empty stages still fill, so in_stall only
// rises once all three hold work. The palette is not cleared by reset.
module sine_pattern_pixel_generator_top #(
	parameter int MAX_DIM = sppg_pkg::MAX_DIM_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output      logic                                 in_stall,
	input  wire logic                                 operation,
	input  wire logic [sppg_pkg::PIX_W-1:0]           pixel_x,
	input  wire logic [sppg_pkg::PIX_W-1:0]           pixel_y,
	input  wire logic [sppg_pkg::FRAME_W-1:0]         frame_count,
	input  wire logic signed [sppg_pkg::OFS_W-1:0]    offset_x,
	input  wire logic signed [sppg_pkg::OFS_W-1:0]    offset_y,
	input  wire logic [sppg_pkg::PAL_IDX_W-1:0]       palette_index,
	input  wire logic [sppg_pkg::COLOR_W-1:0]         palette_color,
	output      logic                                 out_valid,
	input  wire logic                                 out_stall,
	output      logic [sppg_pkg::COLOR_W-1:0]         pixel_color,
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [sppg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sppg_pkg::DIM_W-1:0]           cfg_data
);

	import sppg_pkg::*;

	sppg_cfg_t cfg_q;

	logic                       v_s1, v_s2, v_s3;
	logic                       en1, en2, en3;
	logic                       op_s1, op_s2;
	logic [PIX_W-1:0]           px_s1, py_s1;
	logic [FRAME_W-1:0]         frame_s1;
	logic signed [OFS_W-1:0]    ox_s1, oy_s1;
	logic [PAL_IDX_W-1:0]       pal_idx_s1, addr_s2, calc_addr;
	logic [COLOR_W-1:0]         pal_color_s1, color_s2;
	logic                       ram_we, ram_re;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= FRAME_WIDTH_RST;
			cfg_q.frame_height <= FRAME_HEIGHT_RST;
			cfg_q.pattern_mode <= MODE_PLASMA;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				CFG_PATTERN_MODE: cfg_q.pattern_mode <= cfg_data[MODE_W-1:0];
				default:          ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when its content moves on
	assign en3      = !v_s3 || !out_stall;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2 && (op_s2 == OP_PIXEL);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			op_s1        <= operation;
			px_s1        <= pixel_x;
			py_s1        <= pixel_y;
			frame_s1     <= frame_count;
			ox_s1        <= offset_x;
			oy_s1        <= offset_y;
			pal_idx_s1   <= palette_index;
			pal_color_s1 <= palette_color;
		end
	end

	sppg_index #(
		.MAX_DIM(MAX_DIM)
	) u_index (
		.cfg         (cfg_q),
		.pixel_x     (px_s1),
		.pixel_y     (py_s1),
		.frame_count (frame_s1),
		.offset_x    (ox_s1),
		.offset_y    (oy_s1),
		.palette_addr(calc_addr)
	);

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			op_s2    <= op_s1;
			addr_s2  <= (op_s1 == OP_PALETTE_WRITE) ? pal_idx_s1 : calc_addr;
			color_s2 <= pal_color_s1;
		end
	end

	// writes and reads leave stage 2 in order, so a read sees every earlier write
	assign ram_we = v_s2 && en3 && (op_s2 == OP_PALETTE_WRITE);
	assign ram_re = v_s2 && en3 && (op_s2 == OP_PIXEL);

	sppg_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PAL_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s2),
		.wdata(color_s2),
		.re   (ram_re),
		.raddr(addr_s2),
		.rdata(pixel_color)
	);

	assign out_valid = v_s3;

endmodule

`default_nettype wire

@@ design/sppg_checker.sv @@
// sppg_checker: port-level assertions for the pixel generator, bound to the top.
// Depends on sine_pattern_pixel_generator_top (bind target) and sppg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sppg_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_stall,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic [sppg_pkg::COLOR_W-1:0]    pixel_color,
	input wire logic                            cfg_ready
);

	// a result held back keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_color))
		else $error("pixel result changed while stalled");

	// with the result stage free, the pipeline always takes a transaction
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled although the output side can move");

	// idle input with an unstalled output drains every stage
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!in_valid, 1) && $past(!in_valid, 2) && $past(!in_valid, 3) &&
		$past(!out_stall, 1) && $past(!out_stall, 2) && $past(!out_stall, 3)
		|-> !out_valid)
		else $error("result appeared with no transaction in flight");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind sine_pattern_pixel_generator_top sppg_checker u_sppg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pixel_color(pixel_color),
	.cfg_ready  (cfg_ready)
);

`default_nettype wire

@@ tb/sine_pattern_pixel_generator_top_tb.sv @@
// sine_pattern_pixel_generator_top_tb: self-checking bench for the sine pattern pixel
// generator. Depends on sppg_pkg and sine_pattern_pixel_generator_top.
`timescale 1ns / 1ps

module sine_pattern_pixel_generator_top_tb;
	import sppg_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int DIM_LIMIT   = MAX_DIM_DEFAULT;
	localparam int PIPE_DRAIN  = 8;     // 3-stage pipe plus margin
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 78;
	localparam logic [COLOR_W-1:0] FLAT_COLOR = 16'hC3C3;

	// floor(sin(2*pi*k/256)*127 + 128), k = 0..64
	localparam logic [7:0] QTR_SINE [65] = '{
		8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
		8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd185,
		8'd187, 8'd190, 8'd193, 8'd195, 8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd210,
		8'd213, 8'd215, 8'd217, 8'd219, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd231,
		8'd233, 8'd235, 8'd236, 8'd238, 8'd240, 8'd241, 8'd242, 8'd244, 8'd245, 8'd246,
		8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254,
		8'd254, 8'd254, 8'd254, 8'd254, 8'd255
	};

	typedef struct packed {
		logic                 op;
		logic [PIX_W-1:0]     x;
		logic [PIX_W-1:0]     y;
		logic [FRAME_W-1:0]   frame;
		logic [OFS_W-1:0]     ox;
		logic [OFS_W-1:0]     oy;
		logic [PAL_IDX_W-1:0] pal_idx;
		logic [COLOR_W-1:0]   pal_color;
	} pixel_req_t;

	typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_FILL} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] cfg_idx;
		logic [DIM_W-1:0]     cfg_val;
		pixel_req_t           req;
		logic                 fixed;
		logic [COLOR_W-1:0]   color;
	} stim_row_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   in_valid      = 1'b0;
	logic                   in_stall;
	logic                   operation     = OP_PIXEL;
	logic [PIX_W-1:0]       pixel_x       = '0;
	logic [PIX_W-1:0]       pixel_y       = '0;
	logic [FRAME_W-1:0]     frame_count   = '0;
	logic [OFS_W-1:0]       offset_x      = '0;
	logic [OFS_W-1:0]       offset_y      = '0;
	logic [PAL_IDX_W-1:0]   palette_index = '0;
	logic [COLOR_W-1:0]     palette_color = '0;
	logic                   out_valid;
	logic                   out_stall     = 1'b0;
	logic [COLOR_W-1:0]     pixel_color;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index     = CFG_FRAME_WIDTH;
	logic [DIM_W-1:0]       cfg_data      = '0;

	// mirror of the block state
	logic [COLOR_W-1:0] palette_mirror [PAL_DEPTH];
	logic [DIM_W-1:0]   width_q  = FRAME_WIDTH_RST;
	logic [DIM_W-1:0]   height_q = FRAME_HEIGHT_RST;
	logic [MODE_W-1:0]  mode_q   = MODE_PLASMA;
	logic [7:0]         sine_table [256];

	logic [COLOR_W-1:0] color_q [$];
	logic [COLOR_W-1:0] want_color;
	stim_row_t          stim_table [25];
	int                 err_count = 0;
	int                 idle_pct  = 40;

	sine_pattern_pixel_generator_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.frame_count   (frame_count),
		.offset_x      (offset_x),
		.offset_y      (offset_y),
		.palette_index (palette_index),
		.palette_color (palette_color),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_color   (pixel_color),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		// cap the log; every mismatch still counts
		if (err_count < 50) begin
			$display("%0t mismatch: %s", $time, msg);
		end
		err_count++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r >= idle_pct) return 0;
		if (r < idle_pct / 5) return $urandom_range(30, 8);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic [7:0] wave(input logic [31:0] ph);
		return sine_table[ph[7:0]];
	endfunction

	function automatic logic [COLOR_W-1:0] predict_color(input pixel_req_t r);
		logic [31:0] ox, oy, xx, yy, t, frame, v, idx, d2, a, b, c;
		logic [DIM_W-1:0] w, h;
		int cx, cy, dx, dy;
		ox = {{24{r.ox[7]}}, r.ox};
		oy = {{24{r.oy[7]}}, r.oy};
		frame = 32'(r.frame);
		t = (frame >> 1) & 32'hFF;
		xx = 32'(r.x) + ox;
		yy = 32'(r.y) + oy;
		case (mode_q)
			MODE_RINGS: begin
				w = (width_q > DIM_LIMIT) ? DIM_W'(DIM_LIMIT) : width_q;
				h = (height_q > DIM_LIMIT) ? DIM_W'(DIM_LIMIT) : height_q;
				cx = int'(w >> 1) + int'(ox);
				cy = int'(h >> 1) + int'(oy);
				dx = int'(32'(r.x)) - cx;
				dy = int'(32'(r.y)) - cy;
				d2 = 32'(dx * dx + dy * dy);
				v = 32'(wave((d2 >> 7) - t));
				idx = v + (frame >> 3);
			end
			MODE_WEAVE: begin
				a = 32'(wave(xx + t));
				b = 32'(wave(yy + (t >> 1)));
				c = 32'(wave(((xx + yy) >> 1) - t));
				v = ((a * b) >> 8) + c;
				idx = (v >> 1) + (frame >> 2);
			end
			default: begin
				// plasma, also taken by the spare mode code
				v = 32'(wave(xx + t)) + 32'(wave(yy + (t >> 1)))
				  + 32'(wave(((xx + yy) >> 1) + t)) + 32'(wave(((xx - yy) >> 1) - t));
				idx = (v >> 2) + (frame >> 2);
			end
		endcase
		return palette_mirror[idx[7:0]];
	endfunction

	function automatic logic [PIX_W-1:0] pick_coord();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(7))
			0: return '0;
			1: return 11'd1;
			2: return 11'd2047;
			3: return 11'd1024;
			default: return DIM_W'($urandom_range(1024, 1));
		endcase
	endfunction

	function automatic pixel_req_t random_req();
		pixel_req_t r;
		r.op        = ($urandom_range(99) < 15) ? OP_PALETTE_WRITE : OP_PIXEL;
		r.x         = pick_coord();
		r.y         = pick_coord();
		r.frame     = ($urandom_range(9) == 0) ? {FRAME_W{1'($urandom_range(1))}}
			: FRAME_W'($urandom);
		r.ox        = OFS_W'($urandom);
		r.oy        = OFS_W'($urandom);
		r.pal_idx   = PAL_IDX_W'($urandom);
		r.pal_color = COLOR_W'($urandom);
		return r;
	endfunction

	function automatic pixel_req_t pix(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
			input logic [FRAME_W-1:0] frame, input logic [OFS_W-1:0] ox,
			input logic [OFS_W-1:0] oy);
		pixel_req_t r;
		r = '0;
		r.op = OP_PIXEL;
		r.x = x;
		r.y = y;
		r.frame = frame;
		r.ox = ox;
		r.oy = oy;
		return r;
	endfunction

	function automatic pixel_req_t pal_write(input logic [PAL_IDX_W-1:0] idx,
			input logic [COLOR_W-1:0] color);
		pixel_req_t r;
		r = '0;
		r.op = OP_PALETTE_WRITE;
		r.pal_idx = idx;
		r.pal_color = color;
		return r;
	endfunction

	function automatic stim_row_t row_pix(input pixel_req_t r, input logic fixed,
			input logic [COLOR_W-1:0] color);
		stim_row_t s;
		s = '0;
		s.kind = ROW_ITEM;
		s.req = r;
		s.fixed = fixed;
		s.color = color;
		return s;
	endfunction

	function automatic stim_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [DIM_W-1:0] val);
		stim_row_t s;
		s = '0;
		s.kind = ROW_CFG;
		s.cfg_idx = idx;
		s.cfg_val = val;
		return s;
	endfunction

	function automatic stim_row_t row_fill();
		stim_row_t s;
		s = '0;
		s.kind = ROW_FILL;
		return s;
	endfunction

	// called at a rising edge; returns at the edge where the transaction is taken
	task automatic push_item(input pixel_req_t r, input logic fixed,
			input logic [COLOR_W-1:0] fixed_color);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= r.op;
		pixel_x       <= r.x;
		pixel_y       <= r.y;
		frame_count   <= r.frame;
		offset_x      <= r.ox;
		offset_y      <= r.oy;
		palette_index <= r.pal_idx;
		palette_color <= r.pal_color;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (r.op == OP_PALETTE_WRITE) begin
			palette_mirror[r.pal_idx] = r.pal_color;
		end else begin
			color_q.push_back(fixed ? fixed_color : predict_color(r));
		end
	endtask

	task automatic fill_palette(input logic random_colors, input logic [COLOR_W-1:0] color);
		pixel_req_t r;
		for (int i = 0; i < PAL_DEPTH; i++) begin
			r = random_req();
			r.op = OP_PALETTE_WRITE;
			r.pal_idx = PAL_IDX_W'(i);
			r.pal_color = random_colors ? COLOR_W'($urandom) : color;
			push_item(r, 1'b0, '0);
		end
	endtask

	// palette writes give no result, so wait out the pipe after the last pixel
	task automatic drain();
		in_valid <= 1'b0;
		while (color_q.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FRAME_WIDTH:  width_q = val;
			CFG_FRAME_HEIGHT: height_q = val;
			CFG_PATTERN_MODE: mode_q = val[MODE_W-1:0];
			default: ;
		endcase
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (color_q.size() == 0) begin
				report_mismatch($sformatf("pixel_color %h with nothing expected", pixel_color));
			end else begin
				want_color = color_q.pop_front();
				if (pixel_color !== want_color) begin
					report_mismatch($sformatf("pixel_color %h, expected %h",
						pixel_color, want_color));
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int run;
		@(posedge clk);
		forever begin
			run = gap_len();
			if (run > 0) begin
				out_stall <= 1'b1;
				repeat (run) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	end

	initial begin
		int r;
		// negative half mirrors the positive one; the trough is pinned to 1
		for (int k = 1; k < 64; k++) begin
			sine_table[128 + k] = 8'd255 - QTR_SINE[k];
			sine_table[256 - k] = 8'd255 - QTR_SINE[k];
		end
		for (int k = 0; k <= 64; k++) begin
			sine_table[k] = QTR_SINE[k];
			sine_table[128 - k] = QTR_SINE[k];
		end
		sine_table[192] = 8'd1;

		// rows with a fixed color run on a flat palette, so any index reads FLAT_COLOR
		stim_table = '{
			row_pix(pix(10'd0, 10'd0, 16'h0000, 8'h00, 8'h00), 1'b1, FLAT_COLOR),
			row_pix(pix(10'd1023, 10'd1023, 16'hFFFF, 8'h7F, 8'h7F), 1'b1, FLAT_COLOR),
			row_pix(pix(10'd0, 10'd1023, 16'h0000, 8'h80, 8'h80), 1'b1, FLAT_COLOR),
			row_cfg(CFG_PATTERN_MODE, DIM_W'(MODE_RINGS)),
			row_pix(pix(10'd1023, 10'd0, 16'hFFFF, 8'h80, 8'h7F), 1'b1, FLAT_COLOR),
			row_cfg(CFG_FRAME_WIDTH, 11'd2047),
			row_cfg(CFG_FRAME_HEIGHT, 11'd0),
			row_pix(pix(10'd0, 10'd0, 16'h0000, 8'h7F, 8'h80), 1'b1, FLAT_COLOR),
			row_fill(),
			row_pix(pix(10'd512, 10'd300, 16'd1234, 8'h05, 8'hF9), 1'b0, '0),
			row_pix(pix(10'd1023, 10'd1023, 16'hFFFF, 8'h80, 8'h80), 1'b0, '0),
			row_cfg(CFG_FRAME_WIDTH, 11'd1024),
			row_cfg(CFG_FRAME_HEIGHT, 11'd1),
			row_pix(pix(10'd0, 10'd1023, 16'd8, 8'h7F, 8'h7F), 1'b0, '0),
			row_cfg(CFG_PATTERN_MODE, DIM_W'(MODE_WEAVE)),
			row_pix(pix(10'd1023, 10'd1023, 16'hFFFF, 8'h7F, 8'h7F), 1'b0, '0),
			row_pix(pix(10'd0, 10'd0, 16'h0000, 8'h80, 8'h80), 1'b0, '0),
			row_pix(pal_write(8'd0, 16'h0000), 1'b0, '0),
			row_pix(pal_write(8'd255, 16'hFFFF), 1'b0, '0),
			row_pix(pix(10'd0, 10'd0, 16'h0000, 8'h00, 8'h00), 1'b0, '0),
			row_cfg(CFG_PATTERN_MODE, DIM_W'(MODE_SPARE)),
			row_pix(pix(10'd700, 10'd40, 16'hAAAA, 8'hFF, 8'h01), 1'b0, '0),
			row_pix(pix(10'd1, 10'd2, 16'h5555, 8'h00, 8'h00), 1'b0, '0),
			row_fill(),
			row_pix(pix(10'd300, 10'd200, 16'd77, 8'hFD, 8'h03), 1'b0, '0)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every palette entry is written before any pixel reads it
		fill_palette(1'b0, FLAT_COLOR);

		foreach (stim_table[i]) begin
			case (stim_table[i].kind)
				ROW_CFG:  write_reg(stim_table[i].cfg_idx, stim_table[i].cfg_val);
				ROW_FILL: fill_palette(1'b1, '0);
				default:  push_item(stim_table[i].req, stim_table[i].fixed, stim_table[i].color);
			endcase
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			idle_pct = (ph % 3 == 2) ? 0 : 40;
			write_reg(CFG_FRAME_WIDTH, pick_dim());
			write_reg(CFG_FRAME_HEIGHT, pick_dim());
			r = $urandom_range(9);
			if (r < 3) begin
				write_reg(CFG_PATTERN_MODE, DIM_W'(MODE_PLASMA));
			end else if (r < 6) begin
				write_reg(CFG_PATTERN_MODE, DIM_W'(MODE_RINGS));
			end else if (r < 9) begin
				write_reg(CFG_PATTERN_MODE, DIM_W'(MODE_WEAVE));
			end else begin
				write_reg(CFG_PATTERN_MODE, DIM_W'(MODE_SPARE));
			end
			repeat (PHASE_ITEMS) push_item(random_req(), 1'b0, '0);
		end

		drain();
		if (err_count == 0) begin
			$display("[sine_pattern_pixel_generator_top] OK");
		end else begin
			$display("[sine_pattern_pixel_generator_top] ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[sine_pattern_pixel_generator_top] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
design/sppg_pkg.sv
design/sppg_ram.sv
design/sppg_index.sv
design/sine_pattern_pixel_generator_top.sv
design/sppg_checker.sv
tb/sine_pattern_pixel_generator_top_tb.sv
